// ===== design/pfd_pkg.sv =====
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types and constants for the parameter frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package pfd_pkg;

   // Frame delimiters.
   localparam logic [7:0] FRAME_HEAD = 8'hA5;
   localparam logic [7:0] FRAME_TAIL = 8'h5A;

   // Default number of payload bytes in a frame.
   localparam int PAYLOAD_BYTES_DEF = 4;

   // Bytes that make up the output word.
   localparam int WORD_BYTES = 4;

   // One result item.
   typedef struct packed {
      logic [7:0]  param_id;
      logic [31:0] param_word;
   } rsp_type;

endpackage : pfd_pkg

`default_nettype wire

// ===== design/pfd_if.sv =====
// ----------------------------------------------------------------------------
// pfd_req_if / pfd_rsp_if
// Valid/ready channels for received bytes and decoded parameter items.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface : pfd_req_if

interface pfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  param_id;
   logic [31:0] param_word;

   modport source (output valid, output param_id, output param_word, input ready);
   modport sink (input valid, input param_id, input param_word, output ready);
endinterface : pfd_rsp_if

`default_nettype wire

// ===== design/param_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// param_frame_deframer
// Byte-serial receiver for parameter frames: head, id, payload, additive
// checksum, tail. A good frame yields one item with the id and payload word.
// Throughput: one byte per cycle while req.ready is high; the frame state updates on each accepted byte.
// A finished item is registered into the output stage as its tail byte is accepted.
// req.ready drops only while two finished items wait in the output stage.
// Reset (synchronous, active high) returns to head hunting and empties output.
// ----------------------------------------------------------------------------
`default_nettype none

module param_frame_deframer
   import pfd_pkg::*;
#(
   parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   pfd_req_if.sink   req,
   pfd_rsp_if.source rsp
);

   logic    byte_accept;
   logic    res_valid;
   rsp_type res_data;
   logic    stage_ready;
   rsp_type out_data;

   assign req.ready   = stage_ready;
   assign byte_accept = req.valid && stage_ready;

   // Frame parsing.
   pfd_parser #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .rx_byte     (req.rx_byte),
      .res_valid   (res_valid),
      .res_data    (res_data)
   );

   // Result register and skid.
   pfd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res_data),
      .in_ready  (stage_ready),
      .out_valid (rsp.valid),
      .out_data  (out_data),
      .out_ready (rsp.ready)
   );

   assign rsp.param_id   = out_data.param_id;
   assign rsp.param_word = out_data.param_word;

endmodule : param_frame_deframer

`default_nettype wire

// ===== design/pfd_parser.sv =====
// ----------------------------------------------------------------------------
// pfd_parser
// Frame state machine: tracks head, id, payload, checksum and tail, one byte
// per accepted item, and flags a complete good frame on its tail byte.
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_parser
   import pfd_pkg::*;
#(
   parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       byte_accept,
   input  wire logic [7:0] rx_byte,
   output logic            res_valid,
   output rsp_type         res_data
);

   localparam int CountWidth = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam logic [CountWidth-1:0] LastCount = CountWidth'(PAYLOAD_BYTES - 1);

   // Phase codes.
   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_ID   = 3'd1;
   localparam logic [2:0] PH_DATA = 3'd2;
   localparam logic [2:0] PH_SUM  = 3'd3;
   localparam logic [2:0] PH_TAIL = 3'd4;

   logic [2:0]            phase_ff, phase_in;
   logic [7:0]            frame_id_ff, frame_id_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [7:0]            sum_ff, sum_in;
   logic [7:0]            store_ff [WORD_BYTES];
   logic [7:0]            store_in [WORD_BYTES];

   // Next-state logic for one received byte.
   always_comb begin
      phase_in    = phase_ff;
      frame_id_in = frame_id_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      store_in    = store_ff;
      res_valid   = 1'b0;
      if (byte_accept) begin
         case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == FRAME_HEAD) begin
                  phase_in = PH_ID;
                  sum_in   = '0;
               end
            end
            PH_ID: begin
               frame_id_in = rx_byte;
               sum_in      = rx_byte;
               count_in    = '0;
               for (int i = 0; i < WORD_BYTES; i++) begin
                  store_in[i] = '0;
               end
               phase_in    = PH_DATA;
            end
            PH_DATA: begin
               for (int i = 0; i < WORD_BYTES - 1; i++) begin
                  store_in[i] = store_ff[i+1];
               end
               store_in[WORD_BYTES-1] = rx_byte;
               sum_in = sum_ff + rx_byte;
               if (count_ff == LastCount) begin
                  count_in = '0;
                  phase_in = PH_SUM;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            PH_SUM: begin
               phase_in = (rx_byte == sum_ff) ? PH_TAIL : PH_HUNT;
            end
            PH_TAIL: begin
               res_valid = (rx_byte == FRAME_TAIL);
               phase_in  = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   // The result carries the frame id and the collected payload word.
   always_comb begin
      res_data.param_id = frame_id_ff;
      for (int i = 0; i < WORD_BYTES; i++) begin
         res_data.param_word[8*(WORD_BYTES-1-i) +: 8] = store_ff[i];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         frame_id_ff <= '0;
         count_ff    <= '0;
         sum_ff      <= '0;
      end else begin
         phase_ff    <= phase_in;
         frame_id_ff <= frame_id_in;
         count_ff    <= count_in;
         sum_ff      <= sum_in;
      end
   end

   // Payload bytes, always written before read within a frame.
   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

endmodule : pfd_parser

`default_nettype wire

// ===== design/pfd_out_stage.sv =====
// ----------------------------------------------------------------------------
// pfd_out_stage
// Result register with a one-entry skid, so the input keeps flowing while a
// finished item waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_out_stage
   import pfd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire rsp_type in_data,
   output logic         in_ready,
   output logic         out_valid,
   output rsp_type      out_data,
   input  wire logic    out_ready
);

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    push;

   assign in_ready  = !skid_valid_ff;
   assign push      = in_valid && in_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // Refill the output register from the skid first, then from the input.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            if (push) begin
               out_data_in = in_data;
            end
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule : pfd_out_stage

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the parameter frame deframer. A byte stream of good
// frames, corrupted frames and line noise goes in on req. A scoreboard class
// tracks the framing state in parallel and queues the id/word it expects.
// Every decoded item on rsp is checked against that queue in order. Both
// sides idle and stall in several phases.
// ----------------------------------------------------------------------------

module tb_top
   import pfd_pkg::*;
#(
   parameter int PLEN = PAYLOAD_BYTES_DEF
);

   localparam int RANDOM_BYTES = 520;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 10;

   // Idle and stall chances, in percent, for each phase of the random part.
   localparam int SRC_IDLE[4]  = '{0, 72, 0, 7};
   localparam int SNK_STALL[4] = '{0, 0, 72, 7};

   typedef enum int {
      GOOD_FRAME,
      BAD_SUM_FRAME,
      BAD_TAIL_FRAME,
      LINE_NOISE
   } stream_kind_e;

   // Tracks the frame state in parallel with the block and holds the
   // decoded items that are still due on rsp.
   class param_scoreboard;
      typedef enum logic [2:0] {
         HUNT_HEAD,
         TAKE_ID,
         TAKE_PAYLOAD,
         TAKE_SUM,
         TAKE_TAIL
      } frame_phase_e;

      frame_phase_e phase;
      logic [7:0]   frame_id;
      int unsigned  byte_count;
      logic [7:0]   running_sum;
      logic [31:0]  payload_word;
      rsp_type      expected_q[$];
      int unsigned  mismatches;
      int unsigned  matched;

      function new();
         phase        = HUNT_HEAD;
         frame_id     = '0;
         byte_count   = 0;
         running_sum  = '0;
         payload_word = '0;
         mismatches   = 0;
         matched      = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Advances the frame state by one accepted byte.
      function void note_byte(input logic [7:0] data);
         rsp_type item;
         case (phase)
            HUNT_HEAD: begin
               if (data == FRAME_HEAD) begin
                  phase       = TAKE_ID;
                  running_sum = '0;
               end
            end
            TAKE_ID: begin
               frame_id     = data;
               running_sum  = data;
               byte_count   = 0;
               payload_word = '0;
               phase        = TAKE_PAYLOAD;
            end
            TAKE_PAYLOAD: begin
               // Only the last four payload bytes stay in the word.
               payload_word = {payload_word[23:0], data};
               running_sum  = running_sum + data;
               if (byte_count + 1 >= PLEN) begin
                  byte_count = 0;
                  phase      = TAKE_SUM;
               end else begin
                  byte_count = byte_count + 1;
               end
            end
            TAKE_SUM: begin
               phase = (data == running_sum) ? TAKE_TAIL : HUNT_HEAD;
            end
            TAKE_TAIL: begin
               if (data == FRAME_TAIL) begin
                  item.param_id   = frame_id;
                  item.param_word = payload_word;
                  expected_q.push_back(item);
               end
               phase = HUNT_HEAD;
            end
            default: begin
               phase = HUNT_HEAD;
            end
         endcase
      endfunction

      task report_mismatch(input string what);
         $display("[%0t] MISMATCH: %s", $realtime, what);
         mismatches++;
      endtask

      // Compares one decoded item with the oldest expected one.
      task check_param(input rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected item id %h word %h",
                                      got.param_id, got.param_word));
            return;
         end
         want = expected_q.pop_front();
         if (got.param_id !== want.param_id) begin
            report_mismatch($sformatf("param_id %h, expected %h",
                                      got.param_id, want.param_id));
         end
         if (got.param_word !== want.param_word) begin
            report_mismatch($sformatf("param_word %h, expected %h (id %h)",
                                      got.param_word, want.param_word, want.param_id));
         end
         if (got.param_id === want.param_id && got.param_word === want.param_word) begin
            matched++;
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   pfd_req_if req_ch ();
   pfd_rsp_if rsp_ch ();

   param_scoreboard sb = new();

   int          src_idle_pct  = 0;
   int          snk_stall_pct = 0;
   int unsigned bytes_sent    = 0;
   int unsigned frames_broken = 0;
   int unsigned quiet_cycles  = 0;

   param_frame_deframer #(
      .PAYLOAD_BYTES(PLEN)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   // Clock generation.
   always #6 clock = ~clock;

   // Receiver back-pressure, updated on the falling edge.
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
   end

   // Accepted bytes feed the predictor.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         sb.note_byte(req_ch.rx_byte);
      end
   end

   // Accepted items are checked in order.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
         sb.check_param({rsp_ch.param_id, rsp_ch.param_word});
      end
   end

   // Watchdog: ends the run when no item moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid === 1'b1 && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Watchdog: no item moved for %0d cycles, %0d items still due",
                  IDLE_LIMIT, sb.pending());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Sends one byte; starts and ends on a falling edge.
   task automatic send_byte(input logic [7:0] data);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= data;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   // Sends a whole frame; payload bytes come from the low PLEN bytes, most
   // significant first. A nonzero sum_flip corrupts the checksum byte.
   task automatic send_frame(input logic [7:0] id, input logic [63:0] payload,
                             input logic [7:0] sum_flip, input logic [7:0] tail);
      logic [7:0] sum;
      logic [7:0] data;
      sum = id;
      send_byte(FRAME_HEAD);
      send_byte(id);
      for (int i = PLEN - 1; i >= 0; i--) begin
         data = payload[8*i +: 8];
         sum  = sum + data;
         send_byte(data);
      end
      send_byte(sum ^ sum_flip);
      send_byte(tail);
   endtask

   initial begin
      int unsigned  phase_end;
      stream_kind_e kind;
      logic [63:0]  payload;
      logic [7:0]   tail;

      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      rsp_ch.ready   = 1'b0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: head and tail values inside the payload with a zero id.
      send_frame(8'h00, 64'h0000_0000_FFA5_5A00, 8'h00, FRAME_TAIL);
      // Head value as id; the checksum is wrong and itself equals the head,
      // which must not restart the frame.
      send_frame(FRAME_HEAD, 64'h1, 8'h03, FRAME_TAIL);
      // All-ones frame whose tail is the head value: nothing comes out and
      // that byte must not restart the frame either.
      send_frame(8'hFF, '1, 8'h00, FRAME_HEAD);

      // Random part, one idling pattern per phase.
      for (int ph = 0; ph < 4; ph++) begin
         src_idle_pct  = SRC_IDLE[ph];
         snk_stall_pct = SNK_STALL[ph];
         phase_end     = bytes_sent + RANDOM_BYTES / 4;
         while (bytes_sent < phase_end) begin
            case ($urandom_range(99)) inside
               [0:69]:  kind = GOOD_FRAME;
               [70:79]: kind = BAD_SUM_FRAME;
               [80:89]: kind = BAD_TAIL_FRAME;
               default: kind = LINE_NOISE;
            endcase
            case ($urandom_range(15))
               0:       payload = '0;
               1:       payload = '1;
               default: payload = {$urandom, $urandom};
            endcase
            case (kind)
               GOOD_FRAME: begin
                  send_frame(8'($urandom_range(255)), payload, 8'h00, FRAME_TAIL);
               end
               BAD_SUM_FRAME: begin
                  send_frame(8'($urandom_range(255)), payload,
                             8'($urandom_range(1, 255)), FRAME_TAIL);
                  frames_broken++;
               end
               BAD_TAIL_FRAME: begin
                  tail = 8'($urandom_range(255));
                  if (tail == FRAME_TAIL) begin
                     tail = FRAME_TAIL ^ 8'($urandom_range(1, 255));
                  end
                  send_frame(8'($urandom_range(255)), payload, 8'h00, tail);
                  frames_broken++;
               end
               default: begin
                  repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
               end
            endcase
         end
      end

      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes (%0d frames corrupted on purpose) over four idle/stall phases;",
               bytes_sent, frames_broken);
      $display("%0d decoded items matched, %0d mismatches.", sb.matched, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule : tb_top
